// ===== hdl/gpb_pkg.sv =====
`timescale 1ns / 1ps

// Shared constants and types for the ground-plane back-projection pipeline
package gpb_pkg;

	// Number formats
	localparam int PIXEL_BITS = 12;
	localparam int FRAC_BITS = 16;
	localparam int RAY_BITS = 24;
	localparam int RATIO_LOG = 7;
	localparam int UNIT_BITS = 30;

	// Pipelined units
	localparam int DIV_BITS = 33;
	localparam int SQRT_STAGES = 32;
	localparam int SQRT_IN_BITS = 2 * SQRT_STAGES;

	// Ray whose world z lies below 1e-6 (Q30) does not reach the ground
	localparam logic signed [33:0] UNIT_ZMIN = 34'sd1074;
	localparam logic [30:0] RAY_MAX = '1;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ALT = 2'd1;
	localparam logic [1:0] ST_RAY = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_FOCAL_X = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_CAM_NORTH = 3'd4;
	localparam logic [2:0] REG_CAM_EAST = 3'd5;
	localparam logic [2:0] REG_CAM_DOWN = 3'd6;

	typedef struct packed {
		logic [27:0] focal_x;
		logic [27:0] focal_y;
		logic [27:0] center_x;
		logic [27:0] center_y;
		logic signed [31:0] cam_north;
		logic signed [31:0] cam_east;
		logic signed [31:0] cam_down;
	} cfg_t;

	// Item context carried alongside the ray arithmetic
	typedef struct packed {
		logic signed [31:0] alt;
		logic [8:0][17:0] rot;
		logic sgn_x;
		logic sgn_y;
		logic sat_x;
		logic sat_y;
		logic [30:0] mag_x;
		logic [30:0] mag_y;
	} ray_t;

	// Context carried alongside the ground offset division
	typedef struct packed {
		logic [1:0] status;
		logic sgn_n;
		logic sgn_e;
		logic sat_n;
		logic sat_e;
		logic signed [31:0] down;
	} fin_t;

endpackage

// ===== hdl/gpb_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// The dividend is {rem_in, low_in}; rem_in must be below dsr_in.
module gpb_div (
	input  logic                          clk,
	input  logic [gpb_pkg::DIV_BITS-1:0]  rem_in,
	input  logic [gpb_pkg::DIV_BITS-1:0]  low_in,
	input  logic [gpb_pkg::DIV_BITS-1:0]  dsr_in,
	output logic [gpb_pkg::DIV_BITS-1:0]  quo
);
	localparam int W = gpb_pkg::DIV_BITS;

	logic [W-1:0] rem_s [1:W];
	logic [W-1:0] low_s [1:W];
	logic [W-1:0] dsr_s [1:W];
	logic [W-1:0] quo_s [1:W];

	logic [W-1:0] rem_c [W];
	logic [W-1:0] low_c [W];
	logic [W-1:0] dsr_c [W];
	logic [W-1:0] quo_c [W];
	logic [W+1:0] diff_c [W];
	logic [W:0]   trial_c [W];

	// Stage inputs and trial subtraction
	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (k == 0) begin
				rem_c[k] = rem_in;
				low_c[k] = low_in;
				dsr_c[k] = dsr_in;
				quo_c[k] = '0;
			end else begin
				rem_c[k] = rem_s[k];
				low_c[k] = low_s[k];
				dsr_c[k] = dsr_s[k];
				quo_c[k] = quo_s[k];
			end
			trial_c[k] = {rem_c[k], low_c[k][W-1]};
			diff_c[k] = {1'b0, trial_c[k]} - {2'b00, dsr_c[k]};
		end
	end

	// Stage registers
	always_ff @(posedge clk) begin
		for (int k = 0; k < W; k++) begin
			if (!diff_c[k][W+1]) begin
				rem_s[k+1] <= diff_c[k][W-1:0];
			end else begin
				rem_s[k+1] <= trial_c[k][W-1:0];
			end
			quo_s[k+1] <= {quo_c[k][W-2:0], ~diff_c[k][W+1]};
			low_s[k+1] <= {low_c[k][W-2:0], 1'b0};
			dsr_s[k+1] <= dsr_c[k];
		end
	end

	assign quo = quo_s[W];

endmodule

// ===== hdl/gpb_sqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage
module gpb_sqrt (
	input  logic                              clk,
	input  logic [gpb_pkg::SQRT_IN_BITS-1:0]  x_in,
	output logic [gpb_pkg::SQRT_STAGES-1:0]   root
);
	localparam int N = gpb_pkg::SQRT_STAGES;
	localparam int XW = gpb_pkg::SQRT_IN_BITS;

	logic [N+1:0] r_s [1:N];
	logic [N-1:0] q_s [1:N];
	logic [XW-1:0] x_s [1:N];

	logic [N+1:0] r_c [N];
	logic [N-1:0] q_c [N];
	logic [XW-1:0] x_c [N];
	logic [N+3:0] trial_c [N];
	logic [N+4:0] diff_c [N];

	// Bring down two bits, try 4q+1
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r_c[k] = '0;
				q_c[k] = '0;
				x_c[k] = x_in;
			end else begin
				r_c[k] = r_s[k];
				q_c[k] = q_s[k];
				x_c[k] = x_s[k];
			end
			trial_c[k] = {r_c[k], x_c[k][XW-1:XW-2]};
			diff_c[k] = {1'b0, trial_c[k]} - {3'b000, q_c[k], 2'b01};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (!diff_c[k][N+4]) begin
				r_s[k+1] <= diff_c[k][N+1:0];
			end else begin
				r_s[k+1] <= trial_c[k][N+1:0];
			end
			q_s[k+1] <= {q_c[k][N-2:0], ~diff_c[k][N+4]};
			x_s[k+1] <= {x_c[k][XW-3:0], 2'b00};
		end
	end

	assign root = q_s[N];

endmodule

// ===== hdl/gpb_cfg.sv =====
`timescale 1ns / 1ps

// Configuration register file on the APB-style port
module gpb_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output gpb_pkg::cfg_t        cfg
);
	gpb_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr;

	assign idx = paddr[4:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x <= 28'd65536000;
			cfg_q.focal_y <= 28'd65536000;
			cfg_q.center_x <= 28'd41943040;
			cfg_q.center_y <= 28'd23592960;
			cfg_q.cam_north <= '0;
			cfg_q.cam_east <= '0;
			cfg_q.cam_down <= '0;
		end else if (wr) begin
			case (idx)
				gpb_pkg::REG_FOCAL_X:   cfg_q.focal_x <= pwdata[27:0];
				gpb_pkg::REG_FOCAL_Y:   cfg_q.focal_y <= pwdata[27:0];
				gpb_pkg::REG_CENTER_X:  cfg_q.center_x <= pwdata[27:0];
				gpb_pkg::REG_CENTER_Y:  cfg_q.center_y <= pwdata[27:0];
				gpb_pkg::REG_CAM_NORTH: cfg_q.cam_north <= pwdata;
				gpb_pkg::REG_CAM_EAST:  cfg_q.cam_east <= pwdata;
				gpb_pkg::REG_CAM_DOWN:  cfg_q.cam_down <= pwdata;
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		case (idx)
			gpb_pkg::REG_FOCAL_X:   prdata = {4'h0, cfg_q.focal_x};
			gpb_pkg::REG_FOCAL_Y:   prdata = {4'h0, cfg_q.focal_y};
			gpb_pkg::REG_CENTER_X:  prdata = {4'h0, cfg_q.center_x};
			gpb_pkg::REG_CENTER_Y:  prdata = {4'h0, cfg_q.center_y};
			gpb_pkg::REG_CAM_NORTH: prdata = cfg_q.cam_north;
			gpb_pkg::REG_CAM_EAST:  prdata = cfg_q.cam_east;
			gpb_pkg::REG_CAM_DOWN:  prdata = cfg_q.cam_down;
			default:                prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/pixel_ground_plane_backprojection_top.sv =====
`timescale 1ns / 1ps

// Ground-plane back-projection: one pixel transfer may be started on every clock
// cycle (busy never rises), and its result appears with done high for one cycle,
// in the order the items came in. The datapath holds three 33-stage pipelined
// dividers (ray ratio, unit ray, ground offset) and a 32-stage pipelined square
// root in series. The receiver cannot hold results off, so it must take done
// on every cycle. Further register stages lie between and around these units.
// Registers may be written only while no item is in flight.
module pixel_ground_plane_backprojection_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [11:0]        pixel_col,
	input  logic [11:0]        pixel_row,
	input  logic signed [31:0] height_above,
	input  logic signed [17:0] rot_00,
	input  logic signed [17:0] rot_01,
	input  logic signed [17:0] rot_02,
	input  logic signed [17:0] rot_10,
	input  logic signed [17:0] rot_11,
	input  logic signed [17:0] rot_12,
	input  logic signed [17:0] rot_20,
	input  logic signed [17:0] rot_21,
	input  logic signed [17:0] rot_22,
	output logic               done,
	output logic signed [31:0] ground_north,
	output logic signed [31:0] ground_east,
	output logic signed [31:0] ground_down,
	output logic [1:0]         status
);
	localparam int DW = gpb_pkg::DIV_BITS;
	localparam int FB = gpb_pkg::FRAC_BITS;
	localparam int RB = gpb_pkg::RAY_BITS;
	localparam int UB = gpb_pkg::UNIT_BITS;
	localparam int RL = gpb_pkg::RATIO_LOG;
	localparam int PB = gpb_pkg::PIXEL_BITS;
	localparam int SN = gpb_pkg::SQRT_STAGES;
	localparam logic [RB+UB:0] NUM_Z = {1'b1, {(RB + UB){1'b0}}};

	gpb_pkg::cfg_t cfg;

	gpb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic acc;
	assign busy = 1'b0;
	assign acc = start & ~busy;

	// ---------------- S1: input capture
	logic v_s1;
	logic [PB-1:0] col_s1, row_s1;
	logic signed [31:0] alt_s1;
	logic [8:0][17:0] rot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= pixel_col[PB-1:0];
		row_s1 <= pixel_row[PB-1:0];
		alt_s1 <= height_above;
		rot_s1 <= {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};
	end

	// ---------------- S2: pixel offsets from principal point, steep-ray check
	logic signed [28:0] dx, dy;
	logic [27:0] mx, my, fx_eff, fy_eff;
	logic v_s2;
	gpb_pkg::ray_t ray_s2;

	assign dx = $signed({1'b0, col_s1, {FB{1'b0}}}) - $signed({1'b0, cfg.center_x});
	assign dy = $signed({1'b0, row_s1, {FB{1'b0}}}) - $signed({1'b0, cfg.center_y});
	assign mx = dx[28] ? 28'(-dx) : dx[27:0];
	assign my = dy[28] ? 28'(-dy) : dy[27:0];
	// a zero focal length acts as the smallest one
	assign fx_eff = (cfg.focal_x == '0) ? 28'd1 : cfg.focal_x;
	assign fy_eff = (cfg.focal_y == '0) ? 28'd1 : cfg.focal_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ray_s2.alt <= alt_s1;
		ray_s2.rot <= rot_s1;
		ray_s2.sgn_x <= dx[28];
		ray_s2.sgn_y <= dy[28];
		ray_s2.sat_x <= {{RL{1'b0}}, mx} >= {fx_eff, {RL{1'b0}}};
		ray_s2.sat_y <= {{RL{1'b0}}, my} >= {fy_eff, {RL{1'b0}}};
		ray_s2.mag_x <= 31'(mx);
		ray_s2.mag_y <= 31'(my);
	end

	// ---------------- Ray ratio dividers |d| << 24 / f
	logic [28+RB-1:0] rnum_x, rnum_y;
	logic [DW-1:0] rq_x, rq_y;

	assign rnum_x = {ray_s2.mag_x[27:0], {RB{1'b0}}};
	assign rnum_y = {ray_s2.mag_y[27:0], {RB{1'b0}}};

	gpb_div u_div_rx (
		.clk    (clk),
		.rem_in (DW'(rnum_x >> DW)),
		.low_in (rnum_x[DW-1:0]),
		.dsr_in (DW'(fx_eff)),
		.quo    (rq_x)
	);

	gpb_div u_div_ry (
		.clk    (clk),
		.rem_in (DW'(rnum_y >> DW)),
		.low_in (rnum_y[DW-1:0]),
		.dsr_in (DW'(fy_eff)),
		.quo    (rq_y)
	);

	// context delay alongside the ratio dividers
	gpb_pkg::ray_t ray_d1 [DW];
	logic [DW-1:0] v_d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= '0;
		end else begin
			v_d1 <= {v_d1[DW-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		ray_d1[0] <= ray_s2;
		for (int k = 1; k < DW; k++) begin
			ray_d1[k] <= ray_d1[k-1];
		end
	end

	// ---------------- S3: saturate ratios
	logic v_s3;
	gpb_pkg::ray_t ray_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_d1[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		ray_s3.alt <= ray_d1[DW-1].alt;
		ray_s3.rot <= ray_d1[DW-1].rot;
		ray_s3.sgn_x <= ray_d1[DW-1].sgn_x;
		ray_s3.sgn_y <= ray_d1[DW-1].sgn_y;
		ray_s3.sat_x <= ray_d1[DW-1].sat_x;
		ray_s3.sat_y <= ray_d1[DW-1].sat_y;
		ray_s3.mag_x <= ray_d1[DW-1].sat_x ? gpb_pkg::RAY_MAX : rq_x[30:0];
		ray_s3.mag_y <= ray_d1[DW-1].sat_y ? gpb_pkg::RAY_MAX : rq_y[30:0];
	end

	// ---------------- S4: squares
	logic v_s4;
	gpb_pkg::ray_t ray_s4;
	logic [61:0] sq_x_s4, sq_y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ray_s4 <= ray_s3;
		sq_x_s4 <= 62'(ray_s3.mag_x) * 62'(ray_s3.mag_x);
		sq_y_s4 <= 62'(ray_s3.mag_y) * 62'(ray_s3.mag_y);
	end

	// ---------------- S5: squared length with unit z term
	logic v_s5;
	gpb_pkg::ray_t ray_s5;
	logic [SN*2-1:0] len2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ray_s5 <= ray_s4;
		len2_s5 <= (SN*2)'(sq_x_s4) + (SN*2)'(sq_y_s4) + ((SN*2)'(1) << (2 * RB));
	end

	// ---------------- Norm
	logic [SN-1:0] norm;

	gpb_sqrt u_sqrt (
		.clk  (clk),
		.x_in (len2_s5),
		.root (norm)
	);

	gpb_pkg::ray_t ray_d2 [SN];
	logic [SN-1:0] v_d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d2 <= '0;
		end else begin
			v_d2 <= {v_d2[SN-2:0], v_s5};
		end
	end

	always_ff @(posedge clk) begin
		ray_d2[0] <= ray_s5;
		for (int k = 1; k < SN; k++) begin
			ray_d2[k] <= ray_d2[k-1];
		end
	end

	// ---------------- Unit ray dividers |r| << 30 / norm
	logic [31+UB-1:0] unum_x, unum_y;
	logic [DW-1:0] uq_x, uq_y, uq_z;

	assign unum_x = {ray_d2[SN-1].mag_x, {UB{1'b0}}};
	assign unum_y = {ray_d2[SN-1].mag_y, {UB{1'b0}}};

	gpb_div u_div_nx (
		.clk    (clk),
		.rem_in (DW'(unum_x >> DW)),
		.low_in (unum_x[DW-1:0]),
		.dsr_in (DW'(norm)),
		.quo    (uq_x)
	);

	gpb_div u_div_ny (
		.clk    (clk),
		.rem_in (DW'(unum_y >> DW)),
		.low_in (unum_y[DW-1:0]),
		.dsr_in (DW'(norm)),
		.quo    (uq_y)
	);

	gpb_div u_div_nz (
		.clk    (clk),
		.rem_in (DW'(NUM_Z >> DW)),
		.low_in (NUM_Z[DW-1:0]),
		.dsr_in (DW'(norm)),
		.quo    (uq_z)
	);

	gpb_pkg::ray_t ray_d3 [DW];
	logic [DW-1:0] v_d3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d3 <= '0;
		end else begin
			v_d3 <= {v_d3[DW-2:0], v_d2[SN-1]};
		end
	end

	always_ff @(posedge clk) begin
		ray_d3[0] <= ray_d2[SN-1];
		for (int k = 1; k < DW; k++) begin
			ray_d3[k] <= ray_d3[k-1];
		end
	end

	// ---------------- S6: signed unit ray
	logic v_s6;
	gpb_pkg::ray_t ray_s6;
	logic signed [31:0] n_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_d3[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		ray_s6 <= ray_d3[DW-1];
		n_s6[0] <= ray_d3[DW-1].sgn_x ? 32'(0) - uq_x[31:0] : uq_x[31:0];
		n_s6[1] <= ray_d3[DW-1].sgn_y ? 32'(0) - uq_y[31:0] : uq_y[31:0];
		n_s6[2] <= uq_z[31:0];
	end

	// ---------------- S7: rotation products
	logic v_s7;
	gpb_pkg::ray_t ray_s7;
	logic signed [49:0] prod_s7 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		ray_s7 <= ray_s6;
		for (int k = 0; k < 9; k++) begin
			prod_s7[k] <= $signed(ray_s6.rot[k]) * n_s6[k % 3];
		end
	end

	// ---------------- S8: row sums
	logic v_s8;
	gpb_pkg::ray_t ray_s8;
	logic signed [51:0] acc_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		ray_s8 <= ray_s7;
		for (int i = 0; i < 3; i++) begin
			acc_s8[i] <= 52'(prod_s7[3*i]) + 52'(prod_s7[3*i+1]) + 52'(prod_s7[3*i+2]);
		end
	end

	// ---------------- S9: world ray, clamp, status, down coordinate
	logic signed [51:0] sh [3];
	logic signed [33:0] wc [3];
	logic signed [32:0] dsum;
	logic signed [31:0] down_c;
	logic [1:0] st_c;
	logic v_s9;
	logic signed [33:0] w_s9 [3];
	logic signed [31:0] alt_s9, down_s9;
	logic [1:0] st_s9;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = acc_s8[i] >>> FB;
			if (sh[i] > 52'sd4294967296) begin
				wc[i] = 34'sd4294967296;
			end else if (sh[i] < -52'sd4294967296) begin
				wc[i] = -34'sd4294967296;
			end else begin
				wc[i] = sh[i][33:0];
			end
		end
		dsum = 33'(cfg.cam_down) + 33'(ray_s8.alt);
		if (dsum > 33'sd2147483647) begin
			down_c = 32'sh7fffffff;
		end else if (dsum < -33'sd2147483648) begin
			down_c = 32'sh80000000;
		end else begin
			down_c = dsum[31:0];
		end
		// altitude is checked before the ray direction
		if (ray_s8.alt <= 32'sd0) begin
			st_c = gpb_pkg::ST_ALT;
		end else if (wc[2] < gpb_pkg::UNIT_ZMIN) begin
			st_c = gpb_pkg::ST_RAY;
		end else begin
			st_c = gpb_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		w_s9 <= wc;
		alt_s9 <= ray_s8.alt;
		down_s9 <= down_c;
		st_s9 <= st_c;
	end

	// ---------------- S10: |w| * altitude
	logic [32:0] wm_n, wm_e;
	logic v_s10;
	logic [63:0] p_n_s10, p_e_s10;
	logic [32:0] wz_s10;
	gpb_pkg::fin_t fin_s10;

	assign wm_n = w_s9[0][33] ? 33'(-w_s9[0]) : w_s9[0][32:0];
	assign wm_e = w_s9[1][33] ? 33'(-w_s9[1]) : w_s9[1][32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		p_n_s10 <= {31'h0, wm_n} * {33'h0, alt_s9[30:0]};
		p_e_s10 <= {31'h0, wm_e} * {33'h0, alt_s9[30:0]};
		wz_s10 <= w_s9[2][32:0];
		fin_s10.status <= st_s9;
		fin_s10.sgn_n <= w_s9[0][33];
		fin_s10.sgn_e <= w_s9[1][33];
		fin_s10.sat_n <= 1'b0;
		fin_s10.sat_e <= 1'b0;
		fin_s10.down <= down_s9;
	end

	// ---------------- Ground offset dividers; a quotient of 2^33 or more saturates anyway
	logic [DW-1:0] oq_n, oq_e;
	gpb_pkg::fin_t fin_in;

	always_comb begin
		fin_in = fin_s10;
		fin_in.sat_n = {2'b00, p_n_s10[63:DW]} >= wz_s10;
		fin_in.sat_e = {2'b00, p_e_s10[63:DW]} >= wz_s10;
	end

	gpb_div u_div_on (
		.clk    (clk),
		.rem_in ({2'b00, p_n_s10[63:DW]}),
		.low_in (p_n_s10[DW-1:0]),
		.dsr_in (wz_s10),
		.quo    (oq_n)
	);

	gpb_div u_div_oe (
		.clk    (clk),
		.rem_in ({2'b00, p_e_s10[63:DW]}),
		.low_in (p_e_s10[DW-1:0]),
		.dsr_in (wz_s10),
		.quo    (oq_e)
	);

	gpb_pkg::fin_t fin_d4 [DW];
	logic [DW-1:0] v_d4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d4 <= '0;
		end else begin
			v_d4 <= {v_d4[DW-2:0], v_s10};
		end
	end

	always_ff @(posedge clk) begin
		fin_d4[0] <= fin_in;
		for (int k = 1; k < DW; k++) begin
			fin_d4[k] <= fin_d4[k-1];
		end
	end

	// ---------------- S12: add camera position, saturate, result transfer
	gpb_pkg::fin_t fin_o;
	logic [DW-1:0] qn, qe;
	logic signed [DW:0] off_n, off_e;
	logic signed [34:0] sum_n, sum_e;
	logic signed [31:0] gn_c, ge_c;
	logic v_s12;
	logic signed [31:0] north_s12, east_s12, down_s12;
	logic [1:0] st_s12;

	assign fin_o = fin_d4[DW-1];

	always_comb begin
		qn = fin_o.sat_n ? '1 : oq_n;
		qe = fin_o.sat_e ? '1 : oq_e;
		off_n = fin_o.sgn_n ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
		off_e = fin_o.sgn_e ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
		sum_n = 35'(cfg.cam_north) + 35'(off_n);
		sum_e = 35'(cfg.cam_east) + 35'(off_e);
		if (sum_n > 35'sd2147483647) begin
			gn_c = 32'sh7fffffff;
		end else if (sum_n < -35'sd2147483648) begin
			gn_c = 32'sh80000000;
		end else begin
			gn_c = sum_n[31:0];
		end
		if (sum_e > 35'sd2147483647) begin
			ge_c = 32'sh7fffffff;
		end else if (sum_e < -35'sd2147483648) begin
			ge_c = 32'sh80000000;
		end else begin
			ge_c = sum_e[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_d4[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		st_s12 <= fin_o.status;
		if (fin_o.status == gpb_pkg::ST_OK) begin
			north_s12 <= gn_c;
			east_s12 <= ge_c;
			down_s12 <= fin_o.down;
		end else begin
			north_s12 <= '0;
			east_s12 <= '0;
			down_s12 <= '0;
		end
	end

	assign done = v_s12;
	assign ground_north = north_s12;
	assign ground_east = east_s12;
	assign ground_down = down_s12;
	assign status = st_s12;

	// ---------------- Checks
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != gpb_pkg::ST_OK |->
			ground_north == 32'sd0 && ground_east == 32'sd0 && ground_down == 32'sd0)
		else $error("faulted result carries non-zero coordinates");

	a_div_operands: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && fin_s10.status == gpb_pkg::ST_OK |->
			wz_s10 >= 33'(gpb_pkg::UNIT_ZMIN) && p_n_s10[63] == 1'b0)
		else $error("offset division entered with a bad divisor or product");

	a_tail_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 |-> $past(v_s10, DW + 1))
		else $error("result strobe without a matching item in the offset stage");

	a_ray_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2, DW + 1))
		else $error("ratio stage valid out of step with the divider");

endmodule
